// ===== sv/csvmm_pkg.sv =====
// Shared types, constants and helpers of the CSV column min/max/mean block.
package csvmm_pkg;

    localparam int VALUE_W   = 34;
    localparam int SUM_W     = 48;
    localparam int COUNT_O_W = 24;
    localparam int POW_W     = 27;
    localparam int PROD_W    = VALUE_W + POW_W;
    localparam int K_W       = 4;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 8;

    localparam logic [VALUE_W-1:0] VALUE_LIMIT = 34'd9999999999;
    localparam logic [VALUE_W-1:0] ACC_SAT     = '1;
    localparam logic [SUM_W-1:0]   SUM_MAX     = '1;

    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;

    localparam logic [CFG_IDX_W-1:0] REG_TARGET_COLUMN = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SKIP_HEADER   = 1'b1;

    typedef enum logic [1:0] {
        CAP_IDLE,
        CAP_ON,
        CAP_DONE
    } cap_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DRAIN,
        ST_DIV,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic byte_en;
        logic div_start;
        logic div_step;
        logic load_out;
        logic clear_all;
    } cmd_t;

    typedef struct packed {
        logic pipe_busy;
        logic count_zero;
        logic div_done;
    } status_t;

    function automatic logic [POW_W-1:0] pow10(input logic [K_W-1:0] k);
        logic [POW_W-1:0] r;
        case (k)
            4'd0:    r = 27'd1;
            4'd1:    r = 27'd10;
            4'd2:    r = 27'd100;
            4'd3:    r = 27'd1000;
            4'd4:    r = 27'd10000;
            4'd5:    r = 27'd100000;
            4'd6:    r = 27'd1000000;
            4'd7:    r = 27'd10000000;
            4'd8:    r = 27'd100000000;
            default: r = 27'd1;
        endcase
        return r;
    endfunction

endpackage

// ===== sv/csvmm_div.sv =====
// Restoring divider for the mean: one quotient bit per cycle while step is high.
module csvmm_div #(
    parameter int DIVISOR_W = 24
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic                         step,
    input  logic [csvmm_pkg::SUM_W-1:0]  dividend,
    input  logic [DIVISOR_W-1:0]         divisor,
    output logic [csvmm_pkg::SUM_W-1:0]  quotient,
    output logic                         done
);

    localparam int SW    = csvmm_pkg::SUM_W;
    localparam int CNT_W = $clog2(SW + 1);

    logic [DIVISOR_W-1:0] rem_reg, rem_next;
    logic [SW-1:0]        quot_reg, quot_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [DIVISOR_W:0]   shifted;
    logic [DIVISOR_W:0]   diff;
    logic                 fits;

    always_comb
    begin
        shifted   = {rem_reg, quot_reg[SW-1]};
        diff      = shifted - {1'b0, divisor};
        fits      = shifted >= {1'b0, divisor};
        rem_next  = rem_reg;
        quot_next = quot_reg;
        cnt_next  = cnt_reg;
        if (start)
        begin
            rem_next  = '0;
            quot_next = dividend;
            cnt_next  = '0;
        end
        else if (step)
        begin
            rem_next  = fits ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
            quot_next = {quot_reg[SW-2:0], fits};
            cnt_next  = cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
    end

    assign quotient = quot_reg;
    assign done     = (cnt_reg == CNT_W'(SW));

endmodule

// ===== sv/csvmm_datapath.sv =====
// Datapath: byte parser, line-end scaling pipeline, aggregates, divider and result registers.
module csvmm_datapath #(
    parameter int FRAC_DIGITS = 4,
    parameter int COUNT_BITS  = 24
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  csvmm_pkg::cmd_t                     cmd,
    output csvmm_pkg::status_t                  status,
    input  logic                                cfg_write,
    input  logic [csvmm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [csvmm_pkg::CFG_DAT_W-1:0]     cfg_data,
    input  logic [7:0]                          char_byte,
    input  logic                                end_of_stream,
    output logic [csvmm_pkg::VALUE_W-1:0]       min_value,
    output logic [csvmm_pkg::VALUE_W-1:0]       max_value,
    output logic [csvmm_pkg::VALUE_W-1:0]       mean_value,
    output logic [csvmm_pkg::COUNT_O_W-1:0]     value_count,
    output logic                                none_valid,
    output logic                                overflow
);

    localparam int VW  = csvmm_pkg::VALUE_W;
    localparam int SW  = csvmm_pkg::SUM_W;
    localparam int KW  = csvmm_pkg::K_W;
    localparam int PW  = csvmm_pkg::PROD_W;
    localparam int FW  = (FRAC_DIGITS > 0) ? $clog2(FRAC_DIGITS + 1) : 1;

    // configuration
    logic [7:0] target_reg;
    logic       skip_reg;

    // line state
    logic              quotes_reg, quotes_next;
    logic [7:0]        col_reg, col_next;
    csvmm_pkg::cap_t   cap_reg, cap_next;
    logic              first_reg, first_next;
    logic              digit_reg, digit_next;
    logic [1:0]        dot_reg, dot_next;
    logic [FW-1:0]     frac_reg, frac_next;
    logic [VW-1:0]     accum_reg, accum_next;

    // byte-level work
    logic [3:0]        digit_val;
    logic [VW+3:0]     times_ten;
    logic [VW-1:0]     pushed;
    logic              line_end;
    logic              line_ok;

    // line-end pipeline
    logic              s1_valid_reg;
    logic [VW-1:0]     s1_accum_reg;
    logic [KW-1:0]     s1_k_reg;
    logic              s2_valid_reg;
    logic [PW-1:0]     s2_prod_reg;
    logic              s2_sat_reg;

    // aggregates
    logic [VW-1:0]         min_reg, max_reg;
    logic [SW-1:0]         sum_reg;
    logic [COUNT_BITS-1:0] count_reg;
    logic                  ovf_reg;
    logic [VW-1:0]         upd_val;
    logic                  upd_sat;
    logic [SW:0]           sum_ext;

    // divider
    logic [SW-1:0]     quotient;
    logic              div_done;
    logic              none_now;

    // accumulator and fraction count as left by this byte, before the line clears
    function automatic logic [VW-1:0] accum_next_snapshot();
        logic [VW-1:0] a;
        a = accum_reg;
        if (cmd.byte_en && col_reg == target_reg && cap_reg != csvmm_pkg::CAP_DONE
            && char_byte >= csvmm_pkg::CH_ZERO && char_byte <= csvmm_pkg::CH_NINE
            && !(char_byte == csvmm_pkg::CH_COMMA && !quotes_reg))
        begin
            if (dot_reg == 2'd0
                || (dot_reg == 2'd1 && frac_reg < FW'(FRAC_DIGITS)))
                a = pushed;
        end
        return a;
    endfunction

    function automatic logic [FW-1:0] frac_snapshot();
        logic [FW-1:0] f;
        f = frac_reg;
        if (cmd.byte_en && col_reg == target_reg && cap_reg != csvmm_pkg::CAP_DONE
            && char_byte >= csvmm_pkg::CH_ZERO && char_byte <= csvmm_pkg::CH_NINE
            && dot_reg == 2'd1 && frac_reg < FW'(FRAC_DIGITS))
            f = frac_reg + 1'b1;
        return f;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= '0;
            skip_reg   <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                csvmm_pkg::REG_TARGET_COLUMN: target_reg <= cfg_data;
                csvmm_pkg::REG_SKIP_HEADER:   skip_reg   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        digit_val = 4'(char_byte - csvmm_pkg::CH_ZERO);
        times_ten = ({4'b0, accum_reg} << 3) + ({4'b0, accum_reg} << 1)
                    + (VW+4)'(digit_val);
        pushed = (accum_reg > csvmm_pkg::VALUE_LIMIT
                  || times_ten > (VW+4)'(csvmm_pkg::VALUE_LIMIT))
                 ? csvmm_pkg::ACC_SAT : times_ten[VW-1:0];

        quotes_next = quotes_reg;
        col_next    = col_reg;
        cap_next    = cap_reg;
        first_next  = first_reg;
        digit_next  = digit_reg;
        dot_next    = dot_reg;
        frac_next   = frac_reg;
        accum_next  = accum_reg;

        if (cmd.byte_en)
        begin
            if (char_byte == csvmm_pkg::CH_NEWLINE)
            begin
                // nothing to capture; the line closes below
            end
            else if (char_byte == csvmm_pkg::CH_QUOTE)
            begin
                quotes_next = !quotes_reg;
            end
            else if (char_byte == csvmm_pkg::CH_COMMA && !quotes_reg)
            begin
                if (col_reg != 8'hFF)
                    col_next = col_reg + 8'd1;
                if (cap_reg == csvmm_pkg::CAP_ON)
                    cap_next = csvmm_pkg::CAP_DONE;
            end
            else if (col_reg == target_reg && cap_reg != csvmm_pkg::CAP_DONE)
            begin
                if (char_byte == csvmm_pkg::CH_DOT)
                begin
                    cap_next = csvmm_pkg::CAP_ON;
                    if (dot_reg != 2'd2)
                        dot_next = dot_reg + 2'd1;
                end
                else if (char_byte >= csvmm_pkg::CH_ZERO
                         && char_byte <= csvmm_pkg::CH_NINE)
                begin
                    cap_next   = csvmm_pkg::CAP_ON;
                    digit_next = 1'b1;
                    if (dot_reg == 2'd0)
                    begin
                        accum_next = pushed;
                    end
                    else if (dot_reg == 2'd1 && frac_reg < FW'(FRAC_DIGITS))
                    begin
                        accum_next = pushed;
                        frac_next  = frac_reg + 1'b1;
                    end
                end
            end
        end

        line_end = cmd.byte_en
                   && (char_byte == csvmm_pkg::CH_NEWLINE || end_of_stream);
        line_ok  = digit_next && dot_next != 2'd2 && !(first_reg && skip_reg);

        if (line_end)
        begin
            quotes_next = 1'b0;
            col_next    = '0;
            cap_next    = csvmm_pkg::CAP_IDLE;
            first_next  = 1'b0;
            digit_next  = 1'b0;
            dot_next    = '0;
            frac_next   = '0;
            accum_next  = '0;
        end
        if (cmd.clear_all)
            first_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quotes_reg <= 1'b0;
            col_reg    <= '0;
            cap_reg    <= csvmm_pkg::CAP_IDLE;
            first_reg  <= 1'b1;
            digit_reg  <= 1'b0;
            dot_reg    <= '0;
            frac_reg   <= '0;
            accum_reg  <= '0;
        end
        else
        begin
            quotes_reg <= quotes_next;
            col_reg    <= col_next;
            cap_reg    <= cap_next;
            first_reg  <= first_next;
            digit_reg  <= digit_next;
            dot_reg    <= dot_next;
            frac_reg   <= frac_next;
            accum_reg  <= accum_next;
        end
    end

    // line-end pipeline: snapshot, then scale
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= line_end && line_ok;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_accum_reg <= accum_next_snapshot();
        s1_k_reg     <= KW'(FRAC_DIGITS) - KW'(frac_snapshot());
        s2_prod_reg  <= PW'(s1_accum_reg) * PW'(csvmm_pkg::pow10(s1_k_reg));
        s2_sat_reg   <= s1_accum_reg > csvmm_pkg::VALUE_LIMIT;
    end

    // aggregate update
    always_comb
    begin
        upd_sat = s2_sat_reg || s2_prod_reg > PW'(csvmm_pkg::VALUE_LIMIT);
        upd_val = upd_sat ? csvmm_pkg::VALUE_LIMIT : s2_prod_reg[VW-1:0];
        sum_ext = {1'b0, sum_reg} + (SW+1)'(upd_val);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg   <= csvmm_pkg::ACC_SAT;
            max_reg   <= '0;
            sum_reg   <= '0;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else if (cmd.clear_all)
        begin
            min_reg   <= csvmm_pkg::ACC_SAT;
            max_reg   <= '0;
            sum_reg   <= '0;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else if (s2_valid_reg)
        begin
            if (upd_val < min_reg)
                min_reg <= upd_val;
            if (upd_val > max_reg)
                max_reg <= upd_val;
            if (sum_ext[SW])
                sum_reg <= csvmm_pkg::SUM_MAX;
            else
                sum_reg <= sum_ext[SW-1:0];
            if (count_reg != '1)
                count_reg <= count_reg + 1'b1;
            if (upd_sat || sum_ext[SW])
                ovf_reg <= 1'b1;
        end
    end

    csvmm_div #(
        .DIVISOR_W (COUNT_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .step     (cmd.div_step),
        .dividend (sum_reg),
        .divisor  (count_reg),
        .quotient (quotient),
        .done     (div_done)
    );

    assign none_now = (count_reg == '0);

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            none_valid  <= none_now;
            overflow    <= ovf_reg;
            value_count <= csvmm_pkg::COUNT_O_W'(count_reg);
            min_value   <= none_now ? '0 : min_reg;
            max_value   <= none_now ? '0 : max_reg;
            if (none_now)
                mean_value <= '0;
            else if (quotient > SW'(csvmm_pkg::VALUE_LIMIT))
                mean_value <= csvmm_pkg::VALUE_LIMIT;
            else
                mean_value <= quotient[VW-1:0];
        end
    end

    assign status.pipe_busy  = s1_valid_reg || s2_valid_reg;
    assign status.count_zero = none_now;
    assign status.div_done   = div_done;

endmodule

// ===== sv/csvmm_ctrl.sv =====
// Controller: byte intake, end-of-stream drain, divide sequencing and result hand-off.
module csvmm_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                end_of_stream,
    output logic                out_valid,
    input  logic                out_stall,
    input  csvmm_pkg::status_t  status,
    output csvmm_pkg::cmd_t     cmd
);

    csvmm_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= csvmm_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        out_valid  = 1'b0;
        unique case (state_reg)
            csvmm_pkg::ST_IDLE:
            begin
                in_stall    = 1'b0;
                cmd.byte_en = in_valid;
                if (in_valid && end_of_stream)
                    state_next = csvmm_pkg::ST_DRAIN;
            end
            csvmm_pkg::ST_DRAIN:
            begin
                if (!status.pipe_busy)
                begin
                    if (status.count_zero)
                    begin
                        cmd.load_out  = 1'b1;
                        cmd.clear_all = 1'b1;
                        state_next    = csvmm_pkg::ST_OUT;
                    end
                    else
                    begin
                        cmd.div_start = 1'b1;
                        state_next    = csvmm_pkg::ST_DIV;
                    end
                end
            end
            csvmm_pkg::ST_DIV:
            begin
                if (status.div_done)
                begin
                    cmd.load_out  = 1'b1;
                    cmd.clear_all = 1'b1;
                    state_next    = csvmm_pkg::ST_OUT;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                end
            end
            csvmm_pkg::ST_OUT:
            begin
                out_valid = 1'b1;
                if (!out_stall)
                    state_next = csvmm_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = csvmm_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/csv_column_min_max_mean_core.sv =====
// Top level of the CSV column min/max/mean aggregator.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+------------------------------------------
//  in      | sink      | in_valid / in_stall | char_byte, end_of_stream
//  out     | source    | out_valid/out_stall | min_value, max_value, mean_value,
//          |           |                     | value_count, none_valid, overflow
//  cfg     | sink      | cfg_write           | cfg_index, cfg_data
//
// Cycles: one byte per cycle while a stream runs. After the end-of-stream byte is taken,
// intake holds while the two-stage line-end scaling pipeline drains; the divider is then
// started and divides the 48-bit sum bit-serially for the mean, and the result is loaded
// as out_valid rises (when no value was seen, the divide is skipped and the result loads
// once the pipeline has drained). The result then waits for out_stall to drop, and bytes
// are refused from end of stream until the result is taken.
// Reset (rst_n low, asynchronous) clears the controller, the line state, the aggregates
// and both registers. Result payload registers only load when a result is formed.
module csv_column_min_max_mean_core #(
    parameter int FRAC_DIGITS = 4,
    parameter int COUNT_BITS  = 24
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration
    input  logic                                cfg_write,
    input  logic [csvmm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [csvmm_pkg::CFG_DAT_W-1:0]     cfg_data,
    // text bytes
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [7:0]                          char_byte,
    input  logic                                end_of_stream,
    // aggregate result
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [csvmm_pkg::VALUE_W-1:0]       min_value,
    output logic [csvmm_pkg::VALUE_W-1:0]       max_value,
    output logic [csvmm_pkg::VALUE_W-1:0]       mean_value,
    output logic [csvmm_pkg::COUNT_O_W-1:0]     value_count,
    output logic                                none_valid,
    output logic                                overflow
);

    // command and status between the controller and the datapath
    csvmm_pkg::cmd_t    cmd;
    csvmm_pkg::status_t status;

    // Controller: take bytes in idle, hold intake while the line pipeline drains,
    // step the divider, then present the item until the sink takes it.
    csvmm_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .end_of_stream (end_of_stream),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .cmd           (cmd)
    );

    // Datapath: parse quoting and columns, capture the target field, scale each valid
    // value at line end, fold it into min, max, sum and count, and divide for the mean.
    csvmm_datapath #(
        .FRAC_DIGITS (FRAC_DIGITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .char_byte     (char_byte),
        .end_of_stream (end_of_stream),
        .min_value     (min_value),
        .max_value     (max_value),
        .mean_value    (mean_value),
        .value_count   (value_count),
        .none_valid    (none_valid),
        .overflow      (overflow)
    );

endmodule

// ===== sv/csvmm_checker.sv =====
// Port-level checker for the CSV column aggregator, bound to the top level.
module csvmm_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_stall,
    input  logic                                end_of_stream,
    input  logic                                out_valid,
    input  logic                                out_stall,
    input  logic [csvmm_pkg::VALUE_W-1:0]       min_value,
    input  logic [csvmm_pkg::VALUE_W-1:0]       max_value,
    input  logic [csvmm_pkg::VALUE_W-1:0]       mean_value,
    input  logic [csvmm_pkg::COUNT_O_W-1:0]     value_count,
    input  logic                                none_valid,
    input  logic                                overflow
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(min_value) && $stable(max_value)
            && $stable(mean_value) && $stable(value_count) && $stable(none_valid)
            && $stable(overflow))
        else $error("result changed while stalled");

    // an empty stream gives zero aggregates
    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && none_valid |-> min_value == '0 && max_value == '0
            && mean_value == '0 && value_count == '0)
        else $error("empty result not zero");

    // min never above max, and max never above the value limit, when values were seen
    a_min_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !none_valid |-> min_value <= max_value
            && max_value <= csvmm_pkg::VALUE_LIMIT)
        else $error("min above max or max above limit");

    // the end-of-stream item closes intake until the result is out
    a_eos_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && end_of_stream |=> in_stall)
        else $error("byte taken straight after end of stream");

    a_out_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("byte taken while result pending");

endmodule

bind csv_column_min_max_mean_core csvmm_checker u_csvmm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .end_of_stream (end_of_stream),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .min_value     (min_value),
    .max_value     (max_value),
    .mean_value    (mean_value),
    .value_count   (value_count),
    .none_valid    (none_valid),
    .overflow      (overflow)
);
